// File: rtl/exponential_search_sorted_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted store
// Concurrent checks that are compiled away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_SEARCH_SORTED_STORE_ASSERT_SVH
`define EXPONENTIAL_SEARCH_SORTED_STORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a same-cycle implication outside reset
`define ESS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset
`define ESS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ESS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ESS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Request codes and comparison codes shared by the sorted store modules.
// ----------------------------------------------------------------------------
package ess_pkg;

  // Request opcodes on the mode field
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Width of a stored word and of the reported position
  localparam int WORD_W = 32;
  localparam int POS_W  = 10;

  // Outcome of comparing one stored entry with the key
  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

endpackage

// File: rtl/ess_store_ram.sv
// ----------------------------------------------------------------------------
// ess_store_ram
// Single write port, single read port word store with registered read data.
// ----------------------------------------------------------------------------
module ess_store_ram
  import ess_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [WORD_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [WORD_W-1:0] rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  // Write on request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle into registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ess_probe.sv
// ----------------------------------------------------------------------------
// ess_probe
// Compares one read-back entry with the search key; slots past the fill
// count compare as greater than any key.
// ----------------------------------------------------------------------------
module ess_probe
  import ess_pkg::*;
(
  input  logic                     in_range,
  input  logic signed [WORD_W-1:0] entry,
  input  logic signed [WORD_W-1:0] key,
  output cmp_t                     cmp
);

  // Treat empty slots as larger than every key
  always_comb begin
    if (!in_range) begin
      cmp = CMP_GREATER;
    end else if (entry < key) begin
      cmp = CMP_LESS;
    end else if (entry > key) begin
      cmp = CMP_GREATER;
    end else begin
      cmp = CMP_EQUAL;
    end
  end

endmodule

// File: rtl/exponential_search_sorted_store.sv
// ----------------------------------------------------------------------------
// exponential_search_sorted_store
// Sorted word store with galloping search followed by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with mode and value while busy is low.
//   mode append writes value at the fill count (ignored when the store is
//   full), mode clear empties the store; both leave busy low, so the
//   next request may follow at once. mode 3 is ignored.
//   mode search raises busy and runs one probe per cycle: each probe is one
//   read of the store memory's single read port, compared the next cycle.
//   The gallop doubles the probe index while the entry read is below the
//   key, and the binary phase then searches the bracketed range. The
//   result appears on found and position with done high for exactly one
//   cycle, as busy falls; the receiver cannot stall it. Reset empties the
//   store (fill count to zero), drops any search under way and needs no
//   clearing pass.
// ----------------------------------------------------------------------------
module exponential_search_sorted_store
  import ess_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [WORD_W-1:0] value,
  output logic                     done,
  output logic                     found,
  output logic [POS_W-1:0]         position
);

`include "exponential_search_sorted_store_assert.svh"

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IW = AW + 1;
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int PW = (IW > POS_W) ? IW : POS_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GALLOP = 3'b010,
    ST_BINARY = 3'b100
  } state_t;

  state_t                   state, state_next;
  logic [FW-1:0]            fill_count;
  logic signed [WORD_W-1:0] key;
  logic [IW-1:0]            low, low_next;
  logic [IW-1:0]            high, high_next;
  logic [IW-1:0]            idx, idx_next;
  logic                     in_range;
  logic                     finish, hit;
  logic [IW:0]              mid_sum;
  logic signed [WORD_W-1:0] rdata;
  logic                     accept, wr_en;
  logic [PW-1:0]            pos_ext;
  cmp_t                     cmp;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (mode == MODE_APPEND) &&
                  (fill_count < FW'(STORE_DEPTH));

  ess_store_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_count[AW-1:0]),
    .wdata (value),
    .raddr (idx_next[AW-1:0]),
    .rdata (rdata)
  );

  ess_probe u_probe (
    .in_range (in_range),
    .entry    (rdata),
    .key      (key),
    .cmp      (cmp)
  );

  // Choose the next probe index and bounds from the current comparison
  always_comb begin
    state_next = state;
    low_next   = low;
    high_next  = high;
    idx_next   = idx;
    finish     = 1'b0;
    hit        = 1'b0;
    mid_sum    = '0;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_SEARCH)) begin
          low_next   = '0;
          idx_next   = IW'(1);
          state_next = ST_GALLOP;
        end
      end
      ST_GALLOP: begin
        if (cmp == CMP_LESS) begin
          low_next = idx;
          idx_next = {idx[IW-2:0], 1'b0};
        end else begin
          high_next  = idx;
          mid_sum    = {1'b0, low} + {1'b0, idx};
          idx_next   = mid_sum[IW:1];
          state_next = ST_BINARY;
        end
      end
      ST_BINARY: begin
        case (cmp)
          CMP_EQUAL: begin
            finish = 1'b1;
            hit    = 1'b1;
          end
          CMP_GREATER: begin
            if (idx == low) begin
              finish = 1'b1;
            end else begin
              high_next = idx - IW'(1);
              mid_sum   = {1'b0, low} + {1'b0, high_next};
              idx_next  = mid_sum[IW:1];
            end
          end
          default: begin
            if (idx == high) begin
              finish = 1'b1;
            end else begin
              low_next = idx + IW'(1);
              mid_sum  = {1'b0, low_next} + {1'b0, high};
              idx_next = mid_sum[IW:1];
            end
          end
        endcase
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the search controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold bounds, probe index and key
  always_ff @(posedge clk) begin
    low      <= low_next;
    high     <= high_next;
    idx      <= idx_next;
    in_range <= (idx_next < IW'(fill_count));
    if (accept) begin
      key <= value;
    end
  end

  // Track the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept && (mode == MODE_CLEAR)) begin
      fill_count <= '0;
    end else if (wr_en) begin
      fill_count <= fill_count + FW'(1);
    end
  end

  // Drive the result for one cycle at the end of a search
  assign pos_ext = PW'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      found    <= hit;
      position <= hit ? pos_ext[POS_W-1:0] : '0;
    end
  end

  `ESS_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `ESS_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill_count <= FW'(STORE_DEPTH), "fill overflow")
  `ESS_ASSERT_IMPL(a_miss_pos, clk, rst, done && !found, position == '0, "miss with position")
  `ESS_ASSERT_IMPL(a_range, clk, rst, busy && in_range, idx < IW'(fill_count), "probe past fill")
  `ESS_ASSERT_NEXT(a_finish, clk, rst, finish, done, "finished search gave no result")

endmodule

// File: dv/exponential_search_sorted_store_test.sv
// ----------------------------------------------------------------------------
// exponential_search_sorted_store_test
// Self-checking bench for the sorted store with galloping search. Requests
// (append, search, clear and the unused code) go in as bursts with random
// gaps. A lookup tracker keeps its own copy of the store, works out the
// found flag and position of every accepted search, and compares each
// done strobe against the oldest outstanding lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exponential_search_sorted_store_test;
  import ess_pkg::*;

  localparam int DEPTH = 1024;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WORD_MIN = 32'sh8000_0000;
  localparam int WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_t;

  // Track store contents and outstanding lookups
  class lookup_tracker;
    logic signed [WORD_W-1:0] words [DEPTH];
    int unsigned              fill;
    lookup_t                  lookups_due [$];
    int                       errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // Entries at or beyond the fill count compare as greater than any key
    function cmp_t probe(longint idx, logic signed [WORD_W-1:0] key);
      if (idx < 0 || idx >= longint'(fill)) return CMP_GREATER;
      if (words[idx] < key) return CMP_LESS;
      if (words[idx] > key) return CMP_GREATER;
      return CMP_EQUAL;
    endfunction

    // Gallop, then binary-search the closed range with a floored midpoint
    function lookup_t gallop_lookup(logic signed [WORD_W-1:0] key);
      longint  lo;
      longint  hi;
      longint  mid;
      cmp_t    c;
      lookup_t res;
      lo = 0;
      hi = 1;
      res = '0;
      while (probe(hi, key) == CMP_LESS) begin
        lo = hi;
        hi = 2 * hi;
      end
      while (lo <= hi && !res.found) begin
        mid = (lo + hi) / 2;
        c = probe(mid, key);
        if (c == CMP_GREATER) begin
          hi = mid - 1;
        end else if (c == CMP_LESS) begin
          lo = mid + 1;
        end else begin
          res.found = 1'b1;
          res.position = mid[POS_W-1:0];
        end
      end
      return res;
    endfunction

    function void note_request(logic [1:0] m, logic signed [WORD_W-1:0] v);
      case (m)
        MODE_APPEND: begin
          if (fill < DEPTH) begin
            words[fill] = v;
            fill++;
          end
        end
        MODE_CLEAR: fill = 0;
        MODE_SEARCH: lookups_due.push_back(gallop_lookup(v));
        default: ;
      endcase
    endfunction

    function void check_lookup(logic f, logic [POS_W-1:0] p);
      lookup_t want;
      if (lookups_due.size() == 0) begin
        $display("%0t: result with no search outstanding: found %0b position %0d",
                 $time, f, p);
        errors++;
        return;
      end
      want = lookups_due.pop_front();
      if (f !== want.found) begin
        $display("%0t: found mismatch: expected %0b actual %0b", $time, want.found, f);
        errors++;
      end
      if (p !== want.position) begin
        $display("%0t: position mismatch: expected %0d actual %0d",
                 $time, want.position, p);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               mode;
  logic signed [WORD_W-1:0] value;
  logic                     done;
  logic                     found;
  logic [POS_W-1:0]         position;

  request_t      plan [$];
  int            work_items;
  int            cycles;
  lookup_tracker tracker;

  exponential_search_sorted_store #(
    .STORE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .value    (value),
    .done     (done),
    .found    (found),
    .position (position)
  );

  // Generate the clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Check each result as its strobe cycle ends
  always @(posedge clk) begin
    if (!rst && done) tracker.check_lookup(found, position);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function void add_request(logic [1:0] m, int v);
    request_t r;
    r.mode = m;
    r.value = v;
    plan.push_back(r);
    if (m != MODE_UNUSED) work_items++;
  endfunction

  function int pick_word();
    case ($urandom_range(15))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  // Clear, append a set of words, then search it with a mix of keys
  task automatic plan_episode(int n_app, bit keep_sorted, bit narrow);
    int vals [$];
    int n_look;
    int k;
    int key;
    add_request(MODE_CLEAR, pick_word());
    for (int i = 0; i < n_app; i++) begin
      if (i > 0 && $urandom_range(7) == 0) vals.push_back(vals[i-1]);
      else if (narrow) vals.push_back(int'($urandom_range(200)) - 100);
      else vals.push_back(pick_word());
    end
    if (keep_sorted) vals.sort();
    foreach (vals[i]) add_request(MODE_APPEND, vals[i]);
    n_look = (n_app > 100) ? 40 : $urandom_range(14, 1);
    for (int i = 0; i < n_look; i++) begin
      k = $urandom_range(9);
      if (vals.size() > 0 && k < 5) begin
        key = vals[$urandom_range(vals.size() - 1)];
      end else if (vals.size() > 0 && k < 7) begin
        key = vals[$urandom_range(vals.size() - 1)] + ($urandom_range(1) ? 1 : -1);
      end else if (k < 8) begin
        key = $urandom_range(1) ? WORD_MIN : WORD_MAX;
      end else begin
        key = narrow ? int'($urandom_range(200)) - 100 : pick_word();
      end
      add_request(MODE_SEARCH, key);
      // Sprinkle in ignored codes and out-of-order appends
      if ($urandom_range(19) == 0) add_request(MODE_UNUSED, pick_word());
      if ($urandom_range(29) == 0) add_request(MODE_APPEND, pick_word());
    end
  endtask

  task automatic plan_directed();
    // Empty store, then a single minimum entry
    add_request(MODE_SEARCH, 0);
    add_request(MODE_APPEND, WORD_MIN);
    add_request(MODE_SEARCH, WORD_MIN);
    add_request(MODE_SEARCH, WORD_MAX);
    // Small sorted set with a duplicate and the maximum
    add_request(MODE_APPEND, -5);
    add_request(MODE_APPEND, 0);
    add_request(MODE_APPEND, 7);
    add_request(MODE_APPEND, 7);
    add_request(MODE_APPEND, WORD_MAX);
    add_request(MODE_SEARCH, 7);
    add_request(MODE_SEARCH, -5);
    add_request(MODE_SEARCH, WORD_MAX);
    add_request(MODE_SEARCH, 3);
    add_request(MODE_SEARCH, WORD_MIN);
    add_request(MODE_SEARCH, WORD_MIN + 1);
    add_request(MODE_UNUSED, int'($urandom));
    add_request(MODE_SEARCH, 0);
    // Clear leaves old words behind but they must not be found
    add_request(MODE_CLEAR, 0);
    add_request(MODE_SEARCH, 7);
    add_request(MODE_APPEND, 42);
    add_request(MODE_SEARCH, 42);
    add_request(MODE_APPEND, 41);
    add_request(MODE_SEARCH, 41);
    add_request(MODE_SEARCH, 42);
  endtask

  task automatic plan_random();
    int r;
    work_items = 0;
    // Start with a deep store so the gallop runs many rounds
    plan_episode($urandom_range(250, 150), 1'b1, 1'b0);
    while (work_items < RANDOM_ITEMS) begin
      r = $urandom_range(29);
      if (r < 4) plan_episode($urandom_range(30), 1'b0, $urandom_range(1));
      else plan_episode($urandom_range(40), 1'b1, $urandom_range(1));
    end
  endtask

  // Present requests in bursts; hold each one until it is accepted
  task automatic drive_requests();
    int idx;
    int burst;
    int gap;
    idx = 0;
    burst = $urandom_range(20, 1);
    gap = 0;
    forever begin
      @(posedge clk);
      if (start && !busy) begin
        tracker.note_request(mode, value);
        idx++;
      end
      if (idx >= plan.size()) begin
        start <= 1'b0;
        break;
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          mode <= plan[idx].mode;
          value <= plan[idx].value;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(3) == 0 ? $urandom_range(60, 20) : $urandom_range(12, 1);
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(10, 1);
          end
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    cycles = 0;
    work_items = 0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_APPEND;
    value = '0;
    plan_directed();
    plan_random();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drive_requests();
    // Drain outstanding lookups, then watch for stray strobes
    while (tracker.lookups_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ess_pkg.sv
rtl/ess_store_ram.sv
rtl/ess_probe.sv
rtl/exponential_search_sorted_store.sv
dv/exponential_search_sorted_store_test.sv
